// ===== hdl/skwr_pkg.sv =====
// ----------------------------------------------------------------------------
// skwr_pkg: shared types and constants
// Sizes, command and status codes, the result record and saturation helpers
// for the keyed-removal stack.
// ----------------------------------------------------------------------------
`default_nettype none

package skwr_pkg;

	localparam int STACK_DEPTH = 8;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int KEY_W       = 56;

	localparam int MOVED_W     = 3;
	localparam int OCC_W       = 4;
	localparam int STATUS_W    = 2;
	localparam int OUT_DATA_W  = 8;

	localparam logic CMD_PUSH   = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_PUSHED    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [MOVED_W-1:0]  moved_count;
		logic [OCC_W-1:0]    occupancy;
	} res_t;

	// Counts can be wider than the result fields for deep stacks; clamp them.
	function automatic logic [MOVED_W-1:0] sat_moved(input logic [CNT_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w > 32'((1 << MOVED_W) - 1)) return '1;
		else return w[MOVED_W-1:0];
	endfunction

	function automatic logic [OCC_W-1:0] sat_occ(input logic [CNT_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w > 32'((1 << OCC_W) - 1)) return '1;
		else return w[OCC_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/skwr_ram.sv =====
// ----------------------------------------------------------------------------
// skwr_ram: generic memory
// One write port and one read port per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module skwr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/skwr_seq.sv =====
// ----------------------------------------------------------------------------
// skwr_seq: request sequencer
// Walks the key memory from the top with one shared key comparator, then
// compacts the entries above a match one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skwr_seq import skwr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             in_cmd,
	input  wire logic [KEY_W-1:0] in_key,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output res_t                  res
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_SHIFT  = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [ADDR_W-1:0]   pos_q;
	logic [KEY_W-1:0]    key_q;
	logic [STATUS_W-1:0] status_q;
	logic [MOVED_W-1:0]  moved_q;

	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [KEY_W-1:0]    wr_data;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic [KEY_W-1:0]    rd_data;

	logic                match;
	logic                not_full;
	logic [CNT_W-1:0]    cnt_m1;
	logic [CNT_W-1:0]    pos_p1;
	logic [CNT_W-1:0]    pos_p2;
	logic                shift_last;

	skwr_ram #(
		.WIDTH (KEY_W),
		.DEPTH (STACK_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign match      = (rd_data == key_q);
	assign not_full   = (count_q < CNT_W'(STACK_DEPTH));
	assign cnt_m1     = count_q - CNT_W'(1);
	assign pos_p1     = CNT_W'(pos_q) + CNT_W'(1);
	assign pos_p2     = CNT_W'(pos_q) + CNT_W'(2);
	assign shift_last = (pos_p2 == count_q);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = '{status: status_q, moved_count: moved_q, occupancy: sat_occ(count_q)};

	// Reads run one step ahead: the address issued now is compared next cycle.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = rd_data;
		rd_en   = 1'b0;
		rd_addr = pos_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_cmd == CMD_PUSH && not_full) begin
					wr_en   = 1'b1;
					wr_addr = count_q[ADDR_W-1:0];
					wr_data = in_key;
				end
				if (in_valid && in_cmd == CMD_REMOVE && count_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = cnt_m1[ADDR_W-1:0];
				end
			end
			S_SEARCH: begin
				rd_en = 1'b1;
				if (match) rd_addr = pos_p1[ADDR_W-1:0];
				else rd_addr = pos_q - ADDR_W'(1);
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				rd_en   = !shift_last;
				rd_addr = pos_p2[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			pos_q    <= '0;
			key_q    <= '0;
			status_q <= ST_PUSHED;
			moved_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q   <= in_key;
						moved_q <= '0;
						if (in_cmd == CMD_PUSH) begin
							state_q <= S_DONE;
							if (not_full) begin
								count_q  <= count_q + CNT_W'(1);
								status_q <= ST_PUSHED;
							end else begin
								status_q <= ST_FULL;
							end
						end else if (count_q == '0) begin
							state_q  <= S_DONE;
							status_q <= ST_NOT_FOUND;
						end else begin
							state_q <= S_SEARCH;
							pos_q   <= cnt_m1[ADDR_W-1:0];
						end
					end
				end
				S_SEARCH: begin
					if (match) begin
						status_q <= ST_REMOVED;
						moved_q  <= sat_moved(cnt_m1 - CNT_W'(pos_q));
						if (pos_p1 == count_q) begin
							count_q <= cnt_m1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SHIFT;
						end
					end else if (pos_q == '0) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_DONE;
					end else begin
						pos_q <= pos_q - ADDR_W'(1);
					end
				end
				S_SHIFT: begin
					if (shift_last) begin
						count_q <= cnt_m1;
						state_q <= S_DONE;
					end else begin
						pos_q <= pos_q + ADDR_W'(1);
					end
				end
				S_DONE: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count exceeds depth");

	a_search_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> CNT_W'(pos_q) < count_q)
		else $error("search position outside stored entries");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && in_cmd == CMD_PUSH && not_full)
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted push did not grow the stack");

	a_shift_writes_below: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> pos_p1 < count_q)
		else $error("compaction runs past the top of the stack");

endmodule

`default_nettype wire

// ===== hdl/stack_with_keyed_removal_core.sv =====
// ----------------------------------------------------------------------------
// stack_with_keyed_removal_core: bounded key stack with removal by key
//
// Requests arrive on the s_axis channel: tuser selects push (0) or remove (1),
// tdata carries the 56-bit key. Each request yields exactly one transaction on
// m_axis: tuser holds the status (pushed, full, removed, not found), tdata
// holds the moved count and the occupancy after the request.
// A push needs no search and no compaction before its result. A remove
// compares entries from the top (at most STACK_DEPTH), stopping at the first
// match, then the entries above the match shift down one per cycle.
// The key memory has one read and one write port, and the search and the
// compaction each use it once per cycle. s_axis_tready is high only while the
// sequencer is idle, one request at a time: the next request is taken only
// after the sequencer has handed on the result of the previous one.
// The result sits in an output register, so a new request is taken while the
// previous result waits; when the receiver stalls with a result held, the next
// finished result waits in the sequencer. Reset empties the stack; stored keys
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_keyed_removal_core import skwr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [KEY_W-1:0]      s_axis_tdata,  // key_bytes[55:0]
	input  wire logic                  s_axis_tuser,  // cmd
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // moved_count[2:0], occupancy[6:3]
	output logic [STATUS_W-1:0]        m_axis_tuser   // status
);

	logic res_valid;
	logic res_ready;
	res_t res;

	logic                 m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [STATUS_W-1:0]  m_status_q;

	skwr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_key    (s_axis_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q  <= 1'b0;
			m_data_q   <= '0;
			m_status_q <= ST_PUSHED;
		end else begin
			if (res_ready) begin
				m_valid_q <= res_valid;
				if (res_valid) begin
					m_status_q <= res.status;
					m_data_q   <= OUT_DATA_W'({res.occupancy, res.moved_count});
				end
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_status_q;

endmodule

`default_nettype wire

// ===== tb/stack_with_keyed_removal_core_tb.sv =====
// ----------------------------------------------------------------------------
// stack_with_keyed_removal_core_tb: self-checking bench for the keyed stack
// Drives push and remove requests into the core, mirrors the stack in a
// scoreboard and compares every result transaction field by field. A directed
// run covers the corner cases, and a long random run uses small key pools so
// that removes find their keys. Both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stack_with_keyed_removal_core_tb;
	import skwr_pkg::*;

	localparam int          RANDOM_ITEMS = 1730;
	localparam int          POOL_SIZE    = 8;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	localparam logic [KEY_W-1:0] KEY_ZERO = '0;
	localparam logic [KEY_W-1:0] KEY_ONES = '1;
	localparam logic [KEY_W-1:0] KEY_A    = 56'h41_42_43_44_45_46_47;
	localparam logic [KEY_W-1:0] KEY_B    = 56'h53_54_41_43_4B_30_31;
	localparam logic [KEY_W-1:0] KEY_C    = 56'h41_42_43_44_45_46_46;
	localparam logic [KEY_W-1:0] KEY_D    = 56'h7A_79_78_77_76_75_74;

	// Mirror of the key stack and the queue of results still to arrive.
	class stack_scoreboard;
		logic [KEY_W-1:0] key_mirror [STACK_DEPTH];
		int               depth_used;
		res_t             pending_results[$];
		int unsigned      error_count;

		function new();
			depth_used  = 0;
			error_count = 0;
		endfunction

		function void apply_request(logic cmd, logic [KEY_W-1:0] key);
			res_t res;
			int   idx;
			int   moved;
			bit   found;
			moved = 0;
			found = 1'b0;
			if (cmd == CMD_PUSH) begin
				if (depth_used < STACK_DEPTH) begin
					key_mirror[depth_used] = key;
					depth_used++;
					res.status = ST_PUSHED;
				end else begin
					res.status = ST_FULL;
				end
			end else begin
				// The search runs from the top, so only the topmost match is taken.
				idx = depth_used;
				while (idx > 0 && !found) begin
					idx--;
					if (key_mirror[idx] == key) found = 1'b1;
				end
				if (found) begin
					moved = depth_used - 1 - idx;
					for (int j = idx; j + 1 < depth_used; j++)
						key_mirror[j] = key_mirror[j + 1];
					depth_used--;
					res.status = ST_REMOVED;
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			res.moved_count = (moved > 7) ? 3'd7 : moved[MOVED_W-1:0];
			res.occupancy   = (depth_used > 15) ? 4'd15 : depth_used[OCC_W-1:0];
			pending_results.push_back(res);
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data, logic [STATUS_W-1:0] status);
			res_t want;
			if (pending_results.size() == 0) begin
				$error("result transaction with none expected: status %0d data 0x%02h",
					status, data);
				error_count++;
				return;
			end
			want = pending_results.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, status);
				error_count++;
			end
			if (data[2:0] !== want.moved_count) begin
				$error("moved_count: expected %0d, actual %0d", want.moved_count, data[2:0]);
				error_count++;
			end
			if (data[6:3] !== want.occupancy) begin
				$error("occupancy: expected %0d, actual %0d", want.occupancy, data[6:3]);
				error_count++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [KEY_W-1:0]      s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;

	stack_scoreboard  sb = new();
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	bit               calm;
	bit               hold_req;
	int unsigned      cycle_count;

	stack_with_keyed_removal_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both channels are sampled at the edge, before any driven input changes.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (s_axis_tvalid && s_axis_tready) sb.apply_request(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("stack_with_keyed_removal_core_tb failed");
			$finish;
		end
	end

	// Receiver: random stalls, none while calm, and one long hold-off on request.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(0, 99) >= 22);
			end
		end
	end

	function automatic logic [KEY_W-1:0] random_key();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[KEY_W-1:0];
	endfunction

	// Some pool keys differ from another by one bit, so matching must use all bits.
	function automatic void refresh_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (i > 0 && $urandom_range(0, 3) == 0)
				key_pool[i] = key_pool[$urandom_range(0, i - 1)] ^
					(56'd1 << $urandom_range(0, KEY_W - 1));
			else
				key_pool[i] = random_key();
		end
	endfunction

	task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= key;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (!calm && $urandom_range(0, 99) < 22) begin
			gap = $urandom_range(1, 4);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The first edge lets the monitor note a request accepted at the current edge.
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
	endtask

	initial begin : stimulus
		int          push_pct;
		logic        cmd;
		logic [KEY_W-1:0] key;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser  <= CMD_PUSH;
		s_axis_tdata  <= '0;
		calm          = 1'b0;
		hold_req      = 1'b0;
		cycle_count   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty stack, extreme keys, duplicates, full stack, near misses.
		send_request(CMD_REMOVE, KEY_A);
		send_request(CMD_PUSH,   KEY_ZERO);
		send_request(CMD_PUSH,   KEY_ONES);
		send_request(CMD_PUSH,   KEY_A);
		send_request(CMD_PUSH,   KEY_B);
		send_request(CMD_PUSH,   KEY_A);
		send_request(CMD_REMOVE, KEY_ZERO);
		send_request(CMD_REMOVE, KEY_A);
		send_request(CMD_REMOVE, KEY_C);
		send_request(CMD_PUSH,   KEY_C);
		send_request(CMD_PUSH,   KEY_ZERO);
		send_request(CMD_PUSH,   KEY_D);
		send_request(CMD_PUSH,   KEY_B);
		send_request(CMD_PUSH,   KEY_ONES);
		send_request(CMD_PUSH,   KEY_D);
		send_request(CMD_REMOVE, KEY_ONES);
		send_request(CMD_REMOVE, KEY_ONES);
		send_request(CMD_REMOVE, KEY_B);
		send_request(CMD_REMOVE, KEY_A);
		send_request(CMD_REMOVE, KEY_ZERO);
		send_request(CMD_REMOVE, KEY_ZERO);
		wait_for_results();

		// Random: mostly pooled keys with a push bias drawn anew every block.
		refresh_pool();
		push_pct = 50;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: push_pct = 25;
					1: push_pct = 50;
					2: push_pct = 75;
					default: push_pct = 90;
				endcase
			end
			if (n % 150 == 149) refresh_pool();
			calm = (n >= 700 && n < 1000);
			if (n == 300) hold_req = 1'b1;
			if (n == 1200) wait_for_results();
			cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_REMOVE;
			if ($urandom_range(0, 99) < 80) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else key = random_key();
			send_request(cmd, key);
		end
		calm = 1'b0;

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
			$display("stack_with_keyed_removal_core_tb passed");
		end else begin
			$display("stack_with_keyed_removal_core_tb failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/skwr_pkg.sv
hdl/skwr_ram.sv
hdl/skwr_seq.sv
hdl/stack_with_keyed_removal_core.sv
tb/stack_with_keyed_removal_core_tb.sv
